### rtl/core/rida_pkg.sv
// Shared constants for the recycling identifier allocator.
// No dependencies; imported by rida_stack_mem and recycling_id_allocator.
package rida_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int ID_BITS_DEF     = 16;
    localparam int POOLS           = 3;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUP       = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic [1:0] POOL_BOOK = 2'd0;
    localparam logic [1:0] POOL_FILE = 2'd1;
    localparam logic [1:0] POOL_PAGE = 2'd2;

endpackage

### rtl/core/recycling_id_allocator.sv
// Recycling identifier allocator, top level: three pools, each with a LIFO free stack and a
// fresh-id counter. Uses rida_pkg and rida_stack_mem.
//
// One beat is worked at a time. An allocate goes through S_FIN to the output register, and
// through S_POP first when it pops the free stack, for the stack memory read. A release
// scans the pool's free stack through the single memory read port, one entry per cycle.
// Beats to pool 3 answer id 0 with status ok. A new beat is taken while the previous result
// still waits at the output register.
module recycling_id_allocator
    import rida_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [1:0]  pool,
    input  logic [15:0] id_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] id_out,
    output logic [1:0]  status
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(POOLS * STACK_DEPTH);
    localparam int FR_W   = ID_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg [POOLS];
    logic [CNT_W-1:0]   count_next [POOLS];
    logic [FR_W-1:0]    fresh_reg [POOLS];
    logic [FR_W-1:0]    fresh_next [POOLS];
    logic [1:0]         pool_reg, pool_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               dup_reg, dup_next;
    logic [ID_BITS-1:0] res_id_reg, res_id_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        id_out_reg, id_out_next;
    logic [1:0]         status_reg, status_next;

    logic                  accept;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ID_BITS-1:0]    rd_data;
    logic [ID_BITS+15:0]   id_in_ext;
    logic [ID_BITS-1:0]    id_in_m;
    logic [ID_BITS+15:0]   res_ext;
    logic [CNT_W-1:0]      cnt_in;
    logic [FR_W-1:0]       fresh_in;

    function automatic logic [ADDR_W-1:0] pool_base(input logic [1:0] p);
        logic [ADDR_W-1:0] b;
        unique case (p)
            POOL_BOOK: b = '0;
            POOL_FILE: b = ADDR_W'(STACK_DEPTH);
            POOL_PAGE: b = ADDR_W'(2 * STACK_DEPTH);
            default:   b = '0;
        endcase
        return b;
    endfunction

    rida_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH),
        .ID_BITS     (ID_BITS),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (id_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign id_in_ext = {{ID_BITS{1'b0}}, id_in};
    assign id_in_m   = id_in_ext[ID_BITS-1:0];
    assign res_ext   = {16'h0000, res_id_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        pool_next       = pool_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        dup_next        = dup_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        id_out_next     = id_out_reg;
        status_next     = status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_addr         = '0;
        cnt_in          = '0;
        fresh_in        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pool_next       = pool;
                    id_next         = id_in_m;
                    res_id_next     = '0;
                    res_status_next = ST_OK;
                    if (pool >= 2'(POOLS))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cnt_in   = count_reg[pool];
                        fresh_in = fresh_reg[pool];
                        if (func == FUNC_ALLOC)
                        begin
                            if (cnt_in != '0)
                            begin
                                rd_addr          = pool_base(pool) + ADDR_W'(cnt_in - 1'b1);
                                count_next[pool] = cnt_in - 1'b1;
                                state_next       = S_POP;
                            end
                            else if (!fresh_in[ID_BITS])
                            begin
                                res_id_next      = fresh_in[ID_BITS-1:0];
                                fresh_next[pool] = fresh_in + 1'b1;
                                state_next       = S_FIN;
                            end
                            else
                            begin
                                res_status_next = ST_EXHAUSTED;
                                state_next      = S_FIN;
                            end
                        end
                        else
                        begin
                            cnt_next       = cnt_in;
                            scan_idx_next  = '0;
                            cmp_valid_next = 1'b0;
                            dup_next       = 1'b0;
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            S_POP:
            begin
                res_id_next = rd_data;
                state_next  = S_FIN;
            end

            S_SCAN:
            begin
                cmp_valid_next = 1'b0;
                if (cmp_valid_reg && (rd_data == id_reg))
                begin
                    dup_next = 1'b1;
                end
                if (scan_idx_reg != cnt_reg)
                begin
                    rd_addr        = pool_base(pool_reg) + ADDR_W'(scan_idx_reg);
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    state_next = S_FIN;
                    if (dup_reg)
                    begin
                        res_status_next = ST_DUP;
                    end
                    else if (cnt_reg == CNT_W'(STACK_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en                = 1'b1;
                        wr_addr              = pool_base(pool_reg) + ADDR_W'(cnt_reg);
                        count_next[pool_reg] = cnt_reg + 1'b1;
                    end
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    id_out_next    = res_ext[15:0];
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            dup_reg       <= 1'b0;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < POOLS; i++)
            begin
                count_reg[i] <= '0;
                fresh_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            dup_reg       <= dup_next;
            scan_idx_reg  <= scan_idx_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pool_reg       <= pool_next;
        id_reg         <= id_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        id_out_reg     <= id_out_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign id_out    = id_out_reg;
    assign status    = status_reg;

endmodule

### rtl/core/rida_stack_mem.sv
// Free-stack storage for all pools: one write port, one read port, registered read data.
// Depends on rida_pkg for default sizes.
module rida_stack_mem
    import rida_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int ADDR_W      = $clog2(POOLS * STACK_DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ID_BITS-1:0] wr_data,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ID_BITS-1:0] rd_data
);

    localparam int MEM_DEPTH = POOLS * STACK_DEPTH;

    logic [ID_BITS-1:0] mem [MEM_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### test/rida_grant_checker.sv
// Checker for the recycling identifier allocator: watches both channels, predicts each result
// from its own copy of the pools, and compares it field by field. Depends on rida_pkg.
module rida_grant_checker
    import rida_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        func,
    input  logic [1:0]  pool,
    input  logic [15:0] id_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] id_out,
    input  logic [1:0]  status,
    output int          errors,
    output int          pending,
    output int          results,
    output int          dup_seen,
    output int          full_seen,
    output int          exhausted_seen
);

    localparam logic [ID_BITS_DEF:0] ID_SPACE = {1'b1, {ID_BITS_DEF{1'b0}}};

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  st;
    } grant_t;

    grant_t                 grants_due [$];
    grant_t                 due;
    logic [15:0]            free_ids   [POOLS][STACK_DEPTH_DEF];
    int                     free_count [POOLS];
    logic [ID_BITS_DEF:0]   fresh_next [POOLS];

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want, results);
        errors++;
    endtask

    // Applies one request to the shadow pools and returns the answer it should get.
    function automatic grant_t predict_grant(input logic f, input logic [1:0] p,
                                             input logic [15:0] id);
        grant_t g;
        bit     dup;
        int     n;
        g.id = '0;
        g.st = ST_OK;
        dup  = 1'b0;
        if (p == POOL_BOOK || p == POOL_FILE || p == POOL_PAGE)
        begin
            n = free_count[p];
            if (f == FUNC_ALLOC)
            begin
                if (n > 0)
                begin
                    free_count[p] = n - 1;
                    g.id = free_ids[p][n - 1];
                end
                else if (fresh_next[p] < ID_SPACE)
                begin
                    g.id = fresh_next[p][15:0];
                    fresh_next[p] = fresh_next[p] + 1'b1;
                end
                else
                begin
                    g.st = ST_EXHAUSTED;
                end
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    if (free_ids[p][k] == id)
                        dup = 1'b1;
                if (dup)
                begin
                    g.st = ST_DUP;
                end
                else if (n >= STACK_DEPTH_DEF)
                begin
                    g.st = ST_FULL;
                end
                else
                begin
                    free_ids[p][n] = id;
                    free_count[p] = n + 1;
                end
            end
        end
        return g;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grants_due.delete();
            for (int p = 0; p < POOLS; p++)
            begin
                free_count[p] = 0;
                fresh_next[p] = '0;
            end
            errors         = 0;
            results        = 0;
            dup_seen       = 0;
            full_seen      = 0;
            exhausted_seen = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                grants_due.push_back(predict_grant(func, pool, id_in));
            if (out_valid && !out_stall)
            begin
                if (grants_due.size() == 0)
                begin
                    report_mismatch("unexpected beat, id_out", id_out, 16'h0);
                end
                else
                begin
                    due = grants_due.pop_front();
                    if (id_out !== due.id)
                        report_mismatch("id_out", id_out, due.id);
                    if (status !== due.st)
                        report_mismatch("status", 16'(status), 16'(due.st));
                    if (due.st == ST_DUP)
                        dup_seen++;
                    if (due.st == ST_FULL)
                        full_seen++;
                    if (due.st == ST_EXHAUSTED)
                        exhausted_seen++;
                end
                results++;
            end
        end
        pending = grants_due.size();
    end

endmodule

### test/tb_recycling_id_allocator.sv
// Testbench top for recycling_id_allocator: drives directed and random allocate/release beats
// with random idling, and gives the verdict. Depends on rida_pkg and rida_grant_checker.
module tb_recycling_id_allocator;
    import rida_pkg::*;

    localparam logic [1:0] POOL_UNUSED    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_AFTER     = 40;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = FUNC_ALLOC;
    logic [1:0]  pool = POOL_BOOK;
    logic [15:0] id_in = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] id_out;
    logic [1:0]  status;

    int errors, pending, results, dup_seen, full_seen, exhausted_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int beats_sent = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    recycling_id_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .pool      (pool),
        .id_in     (id_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .id_out    (id_out),
        .status    (status)
    );

    rida_grant_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pool           (pool),
        .id_in          (id_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .id_out         (id_out),
        .status         (status),
        .errors         (errors),
        .pending        (pending),
        .results        (results),
        .dup_seen       (dup_seen),
        .full_seen      (full_seen),
        .exhausted_seen (exhausted_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: one long hold-off early in the run, random stalls otherwise.
    always @(negedge clk)
    begin
        if (!hold_done && beats_sent >= HOLD_AFTER)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic offer_request(input logic f, input logic [1:0] p, input logic [15:0] id);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        pool     <= p;
        id_in    <= id;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
    endtask

    // Distinct releases past the stack depth, then a partial drain.
    task automatic fill_and_drain(input logic [1:0] p);
        logic [15:0] base;
        base = 16'($urandom);
        for (int k = 0; k < STACK_DEPTH_DEF + 2; k++)
            offer_request(FUNC_RELEASE, p, base + 16'(k));
        for (int k = 0; k < 24; k++)
            offer_request(FUNC_ALLOC, p, 16'($urandom));
    endtask

    // Small ids half the time so duplicates and reuse show up often.
    task automatic mixed_requests(input int n);
        logic [1:0]  p;
        logic [15:0] id;
        logic        f;
        for (int k = 0; k < n; k++)
        begin
            p  = ($urandom_range(9) == 0) ? POOL_UNUSED : 2'($urandom_range(2));
            id = $urandom_range(1) ? 16'($urandom_range(23)) : 16'($urandom);
            f  = $urandom_range(1) ? FUNC_RELEASE : FUNC_ALLOC;
            offer_request(f, p, id);
        end
    endtask

    task automatic random_phase(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        fill_and_drain(2'($urandom_range(2)));
        mixed_requests(100);
    endtask

    initial
    begin
        send_idle_pct = 22;
        recv_idle_pct = 67;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed
        offer_request(FUNC_ALLOC,   POOL_BOOK,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_BOOK,   16'hFFFF);
        offer_request(FUNC_ALLOC,   POOL_FILE,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_PAGE,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_UNUSED, 16'hFFFF);
        offer_request(FUNC_RELEASE, POOL_UNUSED, 16'hFFFF);
        offer_request(FUNC_RELEASE, POOL_BOOK,   16'h0000);
        offer_request(FUNC_RELEASE, POOL_BOOK,   16'h0000);
        offer_request(FUNC_RELEASE, POOL_BOOK,   16'hFFFF);
        offer_request(FUNC_ALLOC,   POOL_BOOK,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_BOOK,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_BOOK,   16'h0000);
        offer_request(FUNC_RELEASE, POOL_FILE,   16'hAAAA);
        offer_request(FUNC_RELEASE, POOL_FILE,   16'h5555);
        offer_request(FUNC_RELEASE, POOL_FILE,   16'hAAAA);
        offer_request(FUNC_ALLOC,   POOL_FILE,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_FILE,   16'h0000);
        offer_request(FUNC_ALLOC,   POOL_FILE,   16'h0000);
        offer_request(FUNC_RELEASE, POOL_PAGE,   16'hFFFF);
        offer_request(FUNC_ALLOC,   POOL_PAGE,   16'hFFFF);

        random_phase(22, 67);
        random_phase(67, 22);
        random_phase(0, 0);

        offer_request(FUNC_RELEASE, POOL_PAGE, 16'h1234);
        offer_request(FUNC_RELEASE, POOL_PAGE, 16'h1234);
        offer_request(FUNC_ALLOC,   POOL_PAGE, 16'h0000);
        offer_request(FUNC_ALLOC,   POOL_PAGE, 16'h0000);
        mixed_requests(20);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d results over %0d request beats, including one long output hold-off.",
                 results, beats_sent);
        $display("Seen: %0d duplicate rejects, %0d full-stack drops, %0d exhausted answers.",
                 dup_seen, full_seen, exhausted_seen);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
